// File: rtl/core/wuf_pkg.sv
// Shared types, sizes and command codes for the weighted union-find block.
package wuf_pkg;

  localparam int NUM_ELEMENTS = 8192;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int SIZE_W       = IDX_W + 1;
  localparam int ENT_W        = IDX_W + SIZE_W;
  localparam int ELEM_W       = 13;
  localparam int CNT_W        = 32;

  typedef struct packed {
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;
  } wuf_in_t;

  typedef struct packed {
    logic              already_connected;
    logic [ELEM_W-1:0] merged_root;
    logic [CNT_W-1:0]  connected_count;
  } wuf_out_t;

  // table read address source
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_IN_A   = 2'd0;
  localparam rd_sel_t RD_B      = 2'd1;
  localparam rd_sel_t RD_PARENT = 2'd2;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch_ra;
    logic    latch_rb;
    logic    wr_clear;
    logic    wr_loser;
    logic    wr_winner;
    logic    emit;
    logic    cnt_inc;
  } wuf_cmd_t;

  typedef struct packed {
    logic at_root;
    logic same_root;
    logic a_wins;
    logic clear_last;
  } wuf_stat_t;

endpackage

// File: rtl/core/wuf_dpath.sv
// Datapath: parent/size table, root registers, counter and result register.
module wuf_dpath
  import wuf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  wuf_in_t   in_data,
  input  wuf_cmd_t  cmd,
  output wuf_stat_t stat,
  output wuf_out_t  out_data
);

  // entry: {parent, size}; size only meaningful at a root
  logic [ENT_W-1:0]  mem [NUM_ELEMENTS];
  logic [ENT_W-1:0]  rdata_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_parent;
  logic [SIZE_W-1:0] rd_size;

  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]  node_r, node_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt;
  logic [IDX_W-1:0]  ra_r, ra_nxt;
  logic [IDX_W-1:0]  rb_r, rb_nxt;
  logic [SIZE_W-1:0] sa_r, sa_nxt;
  logic [SIZE_W-1:0] sb_r, sb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  wuf_out_t          out_r, out_nxt;

  logic [IDX_W-1:0]  winner;
  logic [IDX_W-1:0]  loser;
  logic [SIZE_W-1:0] loser_size;
  logic [SIZE_W-1:0] sum_size;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  assign rd_parent = rdata_r[ENT_W-1:SIZE_W];
  assign rd_size   = rdata_r[SIZE_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IN_A:   rd_addr = IDX_W'(in_data.first_element);
      RD_B:      rd_addr = b_r;
      RD_PARENT: rd_addr = rd_parent;
      default:   rd_addr = rd_parent;
    endcase
  end

  assign stat.at_root    = (rd_parent == node_r);
  assign stat.same_root  = (ra_r == rb_r);
  assign stat.a_wins     = (sa_r >= sb_r);
  assign stat.clear_last = (clr_idx_r == IDX_W'(NUM_ELEMENTS - 1));

  assign winner     = stat.a_wins ? ra_r : rb_r;
  assign loser      = stat.a_wins ? rb_r : ra_r;
  assign loser_size = stat.a_wins ? sb_r : sa_r;
  assign sum_size   = sa_r + sb_r;

  always_comb begin
    we      = 1'b0;
    wr_addr = winner;
    wr_data = {winner, sum_size};
    if (cmd.wr_clear) begin
      we      = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = {clr_idx_r, SIZE_W'(1)};
    end else if (cmd.wr_loser) begin
      we      = 1'b1;
      wr_addr = loser;
      wr_data = {winner, loser_size};
    end else if (cmd.wr_winner) begin
      we      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    clr_idx_nxt = cmd.wr_clear ? clr_idx_r + IDX_W'(1) : clr_idx_r;
    node_nxt    = cmd.rd_en ? rd_addr : node_r;
    b_nxt       = cmd.load_in ? IDX_W'(in_data.second_element) : b_r;
    ra_nxt      = cmd.latch_ra ? node_r : ra_r;
    sa_nxt      = cmd.latch_ra ? rd_size : sa_r;
    rb_nxt      = cmd.latch_rb ? node_r : rb_r;
    sb_nxt      = cmd.latch_rb ? rd_size : sb_r;
    cnt_nxt     = cnt_r;
    if (cmd.cnt_inc && (cnt_r != {CNT_W{1'b1}})) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    out_nxt = out_r;
    if (cmd.emit) begin
      out_nxt.already_connected = stat.same_root;
      out_nxt.merged_root       = stat.same_root ? ELEM_W'(ra_r) : ELEM_W'(winner);
      out_nxt.connected_count   = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      cnt_r     <= '0;
    end else begin
      clr_idx_r <= clr_idx_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    b_r    <= b_nxt;
    ra_r   <= ra_nxt;
    sa_r   <= sa_nxt;
    rb_r   <= rb_nxt;
    sb_r   <= sb_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/wuf_ctrl.sv
// Controller: clearing pass, two root walks, merge writes and result handoff.
module wuf_ctrl
  import wuf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  wuf_stat_t stat,
  output wuf_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK_A = 3'd2;
  localparam logic [2:0] S_WALK_B = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  // result register still holds an untaken transaction
  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_PARENT;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_IN_A;
          state_nxt   = S_WALK_A;
        end
      end
      S_WALK_A: begin
        cmd.rd_en = 1'b1;
        if (stat.at_root) begin
          cmd.latch_ra = 1'b1;
          cmd.rd_sel   = RD_B;
          state_nxt    = S_WALK_B;
        end
      end
      S_WALK_B: begin
        if (stat.at_root) begin
          cmd.latch_rb = 1'b1;
          state_nxt    = S_DECIDE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_DECIDE: begin
        if (stat.same_root) begin
          if (!out_busy) begin
            cmd.cnt_inc = 1'b1;
            cmd.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.wr_loser = 1'b1;
          state_nxt    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!out_busy) begin
          cmd.wr_winner = 1'b1;
          cmd.emit      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit | out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_clear, cmd.wr_loser, cmd.wr_winner}))
    else $error("more than one table write");

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_clear || cmd.wr_loser || cmd.wr_winner) |-> !cmd.rd_en)
    else $error("table read and write in one cycle");

  a_loser_then_winner: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_loser |=> (state_r == S_UPDATE))
    else $error("merge left half done");

  a_emit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");
`endif

endmodule

// File: rtl/core/weighted_union_find.sv
// Top level of the weighted union-find block: controller plus datapath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   input    | in_valid / in_stall   | in_data  (first_element, second_element)
//   result   | out_valid / out_stall | out_data (already_connected,
//            |                       |           merged_root, connected_count)
//
// An item walks depth_a + depth_b links, the depths being the links walked to each
// root (at most log2 of NUM_ELEMENTS); a merge adds a final write. The single read
// port of the parent/size table walks one link per cycle.
// After reset a clearing pass initializes the table, with in_stall high. A stalled
// result holds the block before its final write or, with no merge, before its
// emit; a new transaction is taken while the previous result waits.
module weighted_union_find
  import wuf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wuf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output wuf_out_t out_data
);

  wuf_cmd_t  cmd;
  wuf_stat_t stat;

  wuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wuf_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: tb/weighted_union_find_tb.sv
// Self-checking testbench for the weighted union-find block with a predictor of the tree state.
`timescale 1ns / 100ps

module weighted_union_find_tb;
  import wuf_pkg::*;

  localparam int    CLK_PERIOD     = 10;
  localparam int    RANDOM_PAIRS   = 1750;
  localparam int    WINDOW_SPAN    = 128;
  localparam int    ELEM_MAX       = (1 << ELEM_W) - 1;
  localparam int    DRAIN_CYCLES   = 64;
  localparam longint TIMEOUT_CYCLES = 1_000_000;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  wuf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wuf_out_t out_data;

  // shadow copy of the forest
  idx_t           parent_of [NUM_ELEMENTS];
  size_t          set_size  [NUM_ELEMENTS];
  logic [CNT_W-1:0] hit_count = '0;

  wuf_in_t  pending_pairs[$];
  wuf_out_t expected_results[$];
  int       used_elems[$];

  logic in_fire    = 1'b0;
  int   in_gap     = 0;
  int   stall_left = 0;
  int   issued_count = 0;
  int   result_count = 0;
  int   merge_total  = 0;
  int   hit_total    = 0;
  int   biggest_set  = 1;
  int   err_count    = 0;

  weighted_union_find u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic idx_t find_root(idx_t node);
    idx_t walk;
    walk = node;
    for (int steps = 0; steps < NUM_ELEMENTS; steps++) begin
      if (parent_of[walk] == walk) break;
      walk = parent_of[walk];
    end
    return walk;
  endfunction

  // Walk both roots, then join by size; the first root wins a tie.
  function automatic wuf_out_t predict_union(wuf_in_t pair);
    idx_t     ra;
    idx_t     rb;
    idx_t     win;
    wuf_out_t res;
    ra = find_root(idx_t'(pair.first_element));
    rb = find_root(idx_t'(pair.second_element));
    res.already_connected = (ra == rb);
    if (ra == rb) begin
      win = ra;
      if (hit_count != '1) hit_count = hit_count + 1'b1;
      hit_total++;
    end else if (set_size[ra] >= set_size[rb]) begin
      parent_of[rb] = ra;
      set_size[ra]  = set_size[ra] + set_size[rb];
      win = ra;
      merge_total++;
    end else begin
      parent_of[ra] = rb;
      set_size[rb]  = set_size[rb] + set_size[ra];
      win = rb;
      merge_total++;
    end
    if (int'(set_size[win]) > biggest_set) biggest_set = int'(set_size[win]);
    res.merged_root     = ELEM_W'(win);
    res.connected_count = hit_count;
    return res;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_pair(input int a, input int b);
    wuf_in_t p;
    p.first_element  = ELEM_W'(a);
    p.second_element = ELEM_W'(b);
    pending_pairs.insert(pending_pairs.size(), p);
    used_elems.insert(used_elems.size(), a);
    used_elems.insert(used_elems.size(), b);
  endtask

  // Hold during a stall, otherwise present the next pair after its gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (pending_pairs.size() != 0) begin
      in_data  <= pending_pairs.pop_front();
      in_valid <= 1'b1;
      issued_count++;
      if (((issued_count / 128) % 3) == 2 || $urandom_range(0, 99) < 50) in_gap <= 0;
      else in_gap <= idle_length();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (((result_count / 100) % 4) != 3 && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= idle_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    wuf_out_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_results.insert(expected_results.size(), predict_union(in_data));
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: root %0d count %0d",
                                  out_data.merged_root, out_data.connected_count));
      end else begin
        want = expected_results.pop_front();
        if (out_data.already_connected !== want.already_connected)
          report_mismatch($sformatf("result %0d already_connected %b, want %b", result_count,
                                    out_data.already_connected, want.already_connected));
        if (out_data.merged_root !== want.merged_root)
          report_mismatch($sformatf("result %0d merged_root %0d, want %0d", result_count,
                                    out_data.merged_root, want.merged_root));
        if (out_data.connected_count !== want.connected_count)
          report_mismatch($sformatf("result %0d connected_count %0d, want %0d", result_count,
                                    out_data.connected_count, want.connected_count));
      end
    end
  end

  initial begin
    int base;
    int r;
    int a;
    int b;
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      parent_of[i] = idx_t'(i);
      set_size[i]  = size_t'(1);
    end

    add_pair(0, 0);                 // same element twice
    add_pair(0, 1);                 // equal sizes, first root wins
    add_pair(ELEM_MAX, ELEM_MAX - 1);
    add_pair(2, 0);                 // second tree larger
    add_pair(ELEM_MAX, 0);
    add_pair(1, ELEM_MAX - 1);      // already joined through two merges
    add_pair(ELEM_MAX, ELEM_MAX);
    add_pair(3, 4);
    add_pair(5, 6);
    add_pair(3, 5);
    add_pair(4, 6);
    add_pair(6, 0);
    add_pair(ELEM_MAX - 1, 4);
    add_pair('h1555, 'h0AAA);
    add_pair('h0AAA, 'h1555);
    add_pair('h1000, 'h0FFF);
    add_pair(1, 1);

    // mostly pairs inside a moving window so trees grow deep and get rejoined
    base = 0;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 64 == 0) base = $urandom_range(0, ELEM_MAX - WINDOW_SPAN);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        a = base + $urandom_range(0, WINDOW_SPAN - 1);
        b = base + $urandom_range(0, WINDOW_SPAN - 1);
      end else if (r < 70) begin
        a = base + $urandom_range(0, WINDOW_SPAN - 1);
        b = $urandom_range(0, ELEM_MAX);
      end else if (r < 88) begin
        a = used_elems[$urandom_range(0, used_elems.size() - 1)];
        b = used_elems[$urandom_range(0, used_elems.size() - 1)];
      end else if (r < 93) begin
        a = $urandom_range(0, ELEM_MAX);
        b = a;
      end else begin
        a = $urandom_range(0, ELEM_MAX);
        b = $urandom_range(0, ELEM_MAX);
      end
      add_pair(a, b);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pairs: %0d merges, %0d already connected, largest set %0d elements.",
             issued_count, merge_total, hit_total, biggest_set);
    $display("Checked %0d results, %0d mismatches.", result_count, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d pairs queued and %0d results pending.",
             pending_pairs.size(), expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
